// ----- design/bbc_pkg.sv -----
// Shared types and constants of the LRU block buffer cache.
package bbc_pkg;

   typedef enum logic [1:0] {
      REQ_READ    = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_PIN     = 2'd2,
      REQ_UNPIN   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOFREE    = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_ISSUE  = 2'd1,
      S_WAIT   = 2'd2,
      S_COMMIT = 2'd3
   } state_type;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] block;
      logic [7:0]  count;
      logic [31:0] stamp;
   } row_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic issue;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic rsp_busy;
   } stat_type;

endpackage

// ----- design/block_buffer_cache_lru.sv -----
// Top level of the LRU block buffer cache tag and replacement engine.
// One item is handled at a time and each gives exactly one result item. A read
// item walks the entry memory one entry per cycle, looking for a tag hit and for
// the free entry with the oldest release stamp at once, then loads its result;
// release, pin and unpin read one entry. The next item
// can be accepted in the cycle after the result is loaded. A finished result
// sits in an output register, so the next item can be accepted while it waits
// to be taken. There is no clearing pass: per-entry flops mark never-written
// entries, which read as zero.
module block_buffer_cache_lru
   import bbc_pkg::*;
#(
   parameter int ENTRIES = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_entry_index,
   input  logic [31:0] req_now_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_entry_out,
   output logic        rsp_hit,
   output logic        rsp_needs_read,
   output logic [1:0]  rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   bbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bbc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_device       (req_device),
      .req_block_number (req_block_number),
      .req_entry_index  (req_entry_index),
      .req_now_tick     (req_now_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_out    (rsp_entry_out),
      .rsp_hit          (rsp_hit),
      .rsp_needs_read   (rsp_needs_read),
      .rsp_status       (rsp_status)
   );

endmodule

// ----- design/bbc_ctrl.sv -----
// Request sequencer of the LRU block buffer cache.
module bbc_ctrl
   import bbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (stat.scan_last) state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.issue   = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
         end
         S_WAIT: begin
         end
         S_COMMIT: begin
            cmd.commit = !stat.rsp_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- design/bbc_dpath.sv -----
// Entry store, scan logic and result register of the LRU block buffer cache.
module bbc_dpath
   import bbc_pkg::*;
#(
   parameter int ENTRIES = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_entry_index,
   input  logic [31:0] req_now_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_entry_out,
   output logic        rsp_hit,
   output logic        rsp_needs_read,
   output logic [1:0]  rsp_status
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WW = AW + 5;

   // Entry rows live in a memory; per-entry flags live in flops.
   row_type             mem [ENTRIES];
   row_type             mem_q_ff;
   logic [ENTRIES-1:0]  init_ff;
   logic [ENTRIES-1:0]  cvalid_ff;

   req_kind_type        kind_ff;
   logic [7:0]          dev_ff;
   logic [31:0]         blk_ff;
   logic [4:0]          idx_ff;
   logic                in_range_ff;
   logic [31:0]         now_ff;

   logic [AW-1:0]       addr_ff;
   logic                eval_valid_ff;
   logic [AW-1:0]       eval_addr_ff;

   logic                match_ff;
   logic [AW-1:0]       sel_addr_ff;
   row_type             sel_row_ff;
   logic                found_ff;
   logic [31:0]         best_ff;
   logic [AW-1:0]       pick_ff;

   logic                rsp_valid_ff;
   logic [4:0]          rsp_entry_ff;
   logic                rsp_hit_ff;
   logic                rsp_rd_ff;
   status_type          rsp_status_ff;

   logic [WW-1:0]       idx_wide;
   logic [AW-1:0]       idx_addr;
   logic                idx_in_range;
   row_type             eval_row;
   logic                eval_cvalid;
   logic                tag_match;
   logic                free_better;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   row_type             wr_row;
   logic                wr_fill;
   logic [4:0]          out_entry;
   logic                out_hit;
   logic                out_rd;
   status_type          out_status;
   logic [WW-1:0]       sel_wide;
   logic [WW-1:0]       pick_wide;

   assign idx_wide     = WW'(req_entry_index);
   assign idx_addr     = idx_wide[AW-1:0];
   assign idx_in_range = idx_wide < WW'(ENTRIES);

   // A row never written reads as all zero.
   assign eval_row    = init_ff[eval_addr_ff] ? mem_q_ff : '0;
   assign eval_cvalid = cvalid_ff[eval_addr_ff];
   assign tag_match   = eval_cvalid && (eval_row.device == dev_ff)
                        && (eval_row.block == blk_ff);
   assign free_better = (eval_row.count == 8'd0) && (!found_ff || eval_row.stamp < best_ff);

   assign stat.scan_last = (kind_ff != REQ_READ) || (addr_ff == AW'(ENTRIES - 1));
   assign stat.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign sel_wide  = WW'(sel_addr_ff);
   assign pick_wide = WW'(pick_ff);

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = sel_addr_ff;
      wr_row     = sel_row_ff;
      wr_fill    = 1'b0;
      out_entry  = idx_ff;
      out_hit    = 1'b0;
      out_rd     = 1'b0;
      out_status = ST_OK;
      if (kind_ff == REQ_READ) begin
         if (match_ff) begin
            wr_en     = 1'b1;
            if (sel_row_ff.count != COUNT_MAX) wr_row.count = sel_row_ff.count + 8'd1;
            out_entry = sel_wide[4:0];
            out_hit   = 1'b1;
         end else if (found_ff) begin
            wr_en        = 1'b1;
            wr_fill      = 1'b1;
            wr_addr      = pick_ff;
            wr_row.device = dev_ff;
            wr_row.block = blk_ff;
            wr_row.count = 8'd1;
            wr_row.stamp = best_ff;
            out_entry    = pick_wide[4:0];
            out_rd       = 1'b1;
         end else begin
            out_entry  = 5'd0;
            out_status = ST_NOFREE;
         end
      end else if (in_range_ff) begin
         if (kind_ff == REQ_PIN) begin
            wr_en = 1'b1;
            if (sel_row_ff.count != COUNT_MAX) wr_row.count = sel_row_ff.count + 8'd1;
         end else if (sel_row_ff.count == 8'd0) begin
            out_status = ST_UNDERFLOW;
         end else begin
            wr_en        = 1'b1;
            wr_row.count = sel_row_ff.count - 8'd1;
            if (kind_ff == REQ_RELEASE && sel_row_ff.count == 8'd1) wr_row.stamp = now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) mem_q_ff <= mem[addr_ff];
      if (cmd.commit && wr_en) mem[wr_addr] <= wr_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff       <= '0;
         cvalid_ff     <= '0;
         eval_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         match_ff      <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         eval_valid_ff <= cmd.issue;
         if (cmd.capture) begin
            match_ff <= 1'b0;
            found_ff <= 1'b0;
         end else if (eval_valid_ff && kind_ff == REQ_READ) begin
            if (!match_ff && tag_match) match_ff <= 1'b1;
            if (free_better) found_ff <= 1'b1;
         end
         if (cmd.commit && wr_en) begin
            init_ff[wr_addr] <= 1'b1;
            if (wr_fill) cvalid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind_type'(req_type);
         dev_ff      <= req_device;
         blk_ff      <= req_block_number;
         idx_ff      <= req_entry_index;
         in_range_ff <= idx_in_range;
         now_ff      <= req_now_tick;
         addr_ff     <= (req_kind_type'(req_type) == REQ_READ) ? '0 : idx_addr;
         sel_addr_ff <= idx_addr;
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + AW'(1);
      end
      if (cmd.issue) eval_addr_ff <= addr_ff;
      if (eval_valid_ff) begin
         if (kind_ff != REQ_READ) begin
            sel_row_ff <= eval_row;
         end else if (!match_ff && tag_match) begin
            sel_row_ff  <= eval_row;
            sel_addr_ff <= eval_addr_ff;
         end
         if (kind_ff == REQ_READ && free_better) begin
            best_ff <= eval_row.stamp;
            pick_ff <= eval_addr_ff;
         end
      end
      if (cmd.commit) begin
         rsp_entry_ff  <= out_entry;
         rsp_hit_ff    <= out_hit;
         rsp_rd_ff     <= out_rd;
         rsp_status_ff <= out_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_entry_out  = rsp_entry_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_needs_read = rsp_rd_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ----- bench/testbench.sv -----
// Testbench for the LRU block buffer cache: directed and random requests checked against a predictor.
module testbench;
   import bbc_pkg::*;

   localparam int ENTRIES = 32;
   localparam int TOTAL_ITEMS = 1900;
   localparam int TAG_POOL = 44;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      req_kind_type kind;
      logic [7:0]   device;
      logic [31:0]  block;
      logic [4:0]   index;
      logic [31:0]  tick;
   } cache_req_type;

   typedef struct {
      logic [4:0] entry;
      logic       hit;
      logic       needs_read;
      status_type status;
   } grant_type;

   typedef struct {
      cache_req_type req;
      bit            typed;
      grant_type     want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic [7:0]  req_device = '0;
   logic [31:0] req_block_number = '0;
   logic [4:0]  req_entry_index = '0;
   logic [31:0] req_now_tick = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_entry_out;
   logic        rsp_hit;
   logic        rsp_needs_read;
   logic [1:0]  rsp_status;

   // Predicted copy of the entry array.
   bit [7:0]  line_dev [ENTRIES];
   bit [31:0] line_blk [ENTRIES];
   bit        line_filled [ENTRIES];
   bit [7:0]  line_refs [ENTRIES];
   bit [31:0] line_stamp [ENTRIES];

   grant_type   grant_q[$];
   grant_type   oldest_grant;
   dir_row_type dir_table[$];
   logic [7:0]  pool_dev [TAG_POOL];
   logic [31:0] pool_blk [TAG_POOL];
   logic [31:0] tick_now = '0;

   int req_idle_pct = 14;
   int rsp_idle_pct = 14;
   bit hold_trigger = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int hits_seen = 0;
   int nofree_seen = 0;
   int underflow_seen = 0;
   int saturate_seen = 0;

   block_buffer_cache_lru #(.ENTRIES(ENTRIES)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_device       (req_device),
      .req_block_number (req_block_number),
      .req_entry_index  (req_entry_index),
      .req_now_tick     (req_now_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_out    (rsp_entry_out),
      .rsp_hit          (rsp_hit),
      .rsp_needs_read   (rsp_needs_read),
      .rsp_status       (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Works out the result of one request and updates the predicted entry array.
   function automatic grant_type predict_grant(input cache_req_type r);
      grant_type   g;
      bit          found;
      int          pick;
      logic [31:0] oldest;
      g.entry = r.index;
      g.hit = 1'b0;
      g.needs_read = 1'b0;
      g.status = ST_OK;
      found = 1'b0;
      pick = 0;
      oldest = '0;
      if (r.kind == REQ_READ) begin
         g.entry = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (line_filled[i] && line_dev[i] == r.device && line_blk[i] == r.block) begin
               if (line_refs[i] != COUNT_MAX) line_refs[i]++;
               hits_seen++;
               g.entry = 5'(i);
               g.hit = 1'b1;
               return g;
            end
         end
         // Oldest release stamp among unreferenced entries; strict compare keeps the lowest index.
         for (int i = 0; i < ENTRIES; i++) begin
            if (line_refs[i] == 0 && (!found || line_stamp[i] < oldest)) begin
               found = 1'b1;
               oldest = line_stamp[i];
               pick = i;
            end
         end
         if (!found) begin
            g.status = ST_NOFREE;
            nofree_seen++;
            return g;
         end
         line_dev[pick] = r.device;
         line_blk[pick] = r.block;
         line_refs[pick] = 8'd1;
         line_filled[pick] = 1'b1;
         g.entry = 5'(pick);
         g.needs_read = 1'b1;
      end else if (r.index < ENTRIES) begin
         if (r.kind == REQ_PIN) begin
            if (line_refs[r.index] == COUNT_MAX) saturate_seen++;
            else line_refs[r.index]++;
         end else if (line_refs[r.index] == 0) begin
            g.status = ST_UNDERFLOW;
            underflow_seen++;
         end else begin
            line_refs[r.index]--;
            if (r.kind == REQ_RELEASE && line_refs[r.index] == 0) line_stamp[r.index] = r.tick;
         end
      end
      return g;
   endfunction

   function automatic dir_row_type mk_row(input req_kind_type kind, input logic [7:0] dev,
                                          input logic [31:0] blk, input logic [4:0] idx,
                                          input logic [31:0] tick, input bit typed,
                                          input logic [4:0] entry, input logic hit,
                                          input logic rd, input status_type st);
      dir_row_type row;
      row.req = '{kind: kind, device: dev, block: blk, index: idx, tick: tick};
      row.typed = typed;
      row.want = '{entry: entry, hit: hit, needs_read: rd, status: st};
      return row;
   endfunction

   // The release tick mostly repeats or creeps forward and sometimes jumps anywhere.
   function automatic logic [31:0] next_tick();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) tick_now = tick_now;
      else if (roll < 90) tick_now = tick_now + $urandom_range(40, 1);
      else if (roll < 95) tick_now = $urandom;
      else tick_now = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      return tick_now;
   endfunction

   function automatic cache_req_type read_req(input logic [7:0] dev, input logic [31:0] blk);
      cache_req_type r;
      r = '{kind: REQ_READ, device: dev, block: blk, index: 5'($urandom), tick: $urandom};
      return r;
   endfunction

   function automatic cache_req_type entry_req(input req_kind_type kind, input logic [4:0] idx,
                                               input logic [31:0] tick);
      cache_req_type r;
      r = '{kind: kind, device: 8'($urandom), block: $urandom, index: idx, tick: tick};
      return r;
   endfunction

   // Picks an entry that holds references, or any entry when none does.
   function automatic logic [4:0] pick_held();
      int start;
      start = $urandom_range(ENTRIES - 1);
      for (int i = 0; i < ENTRIES; i++) begin
         if (line_refs[(start + i) % ENTRIES] != 0) return 5'((start + i) % ENTRIES);
      end
      return 5'(start);
   endfunction

   task automatic send_req(input cache_req_type r, input bit typed, input grant_type want);
      grant_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_device <= r.device;
      req_block_number <= r.block;
      req_entry_index <= r.index;
      req_now_tick <= r.tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_grant(r);
      grant_q.push_back(typed ? want : predicted);
      req_count++;
   endtask

   // Receiver: random stalls, plus one long hold-off that lets the block back up.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_trigger && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (grant_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual entry %0d status %0d",
                     $time, rsp_entry_out, rsp_status);
            mismatch_count++;
         end else begin
            oldest_grant = grant_q.pop_front();
            check_field("entry_out", oldest_grant.entry, rsp_entry_out);
            check_field("hit", oldest_grant.hit, rsp_hit);
            check_field("needs_read", oldest_grant.needs_read, rsp_needs_read);
            check_field("status", oldest_grant.status, rsp_status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      grant_type   none;
      int          roll;
      int          burst;
      int          start;
      bit          any_free;
      bit          storm_done;
      logic [4:0]  idx;
      logic [31:0] drain_tick;
      bit          same_tick;

      none = '{entry: '0, hit: 1'b0, needs_read: 1'b0, status: ST_OK};
      storm_done = 1'b0;

      // Typed rows follow from the empty cache; the rest rely on the predictor.
      dir_table.push_back(mk_row(REQ_READ, 8'h00, 32'h0000_0000, 5'd0, 32'h0,
                                 1, 5'd0, 1'b0, 1'b1, ST_OK));
      dir_table.push_back(mk_row(REQ_READ, 8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF,
                                 1, 5'd0, 1'b1, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_READ, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0,
                                 1, 5'd1, 1'b0, 1'b1, ST_OK));
      dir_table.push_back(mk_row(REQ_RELEASE, 8'hA5, 32'h5A5A_5A5A, 5'd5, 32'h10,
                                 1, 5'd5, 1'b0, 1'b0, ST_UNDERFLOW));
      dir_table.push_back(mk_row(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'h11,
                                 1, 5'd31, 1'b0, 1'b0, ST_UNDERFLOW));
      dir_table.push_back(mk_row(REQ_PIN, 8'h00, 32'h0, 5'd31, 32'h12,
                                 1, 5'd31, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_UNPIN, 8'h00, 32'h0, 5'd31, 32'h13,
                                 1, 5'd31, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'hFFFF_FFFF,
                                 1, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'hFFFF_FFFF,
                                 1, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0,
                                 1, 5'd0, 1'b0, 1'b0, ST_UNDERFLOW));
      dir_table.push_back(mk_row(REQ_RELEASE, 8'h00, 32'h0, 5'd1, 32'h7,
                                 1, 5'd1, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_READ, 8'h01, 32'h0000_0001, 5'd0, 32'h0,
                                 0, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_READ, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0,
                                 0, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_READ, 8'h00, 32'h0000_0000, 5'd0, 32'h0,
                                 0, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_READ, 8'h00, 32'h0000_0001, 5'd0, 32'h0,
                                 0, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_READ, 8'h01, 32'h0000_0000, 5'd0, 32'h0,
                                 0, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_PIN, 8'h00, 32'h0, 5'd3, 32'h0,
                                 0, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_UNPIN, 8'h00, 32'h0, 5'd2, 32'h0,
                                 0, 5'd0, 1'b0, 1'b0, ST_OK));
      dir_table.push_back(mk_row(REQ_RELEASE, 8'h00, 32'h0, 5'd16, 32'h8000_0000,
                                 1, 5'd16, 1'b0, 1'b0, ST_UNDERFLOW));

      for (int i = 0; i < TAG_POOL; i++) begin
         pool_dev[i] = (i < 4) ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
         pool_blk[i] = (i < 4) ? ((i / 2) ? 32'hFFFF_FFFF : 32'h0) : $urandom;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].want);

      while (req_count < TOTAL_ITEMS) begin
         if (req_count >= 200) hold_trigger <= 1'b1;
         // A stretch with no idling on either side.
         req_idle_pct = (req_count >= 900 && req_count < 1200) ? 0 : 14;
         rsp_idle_pct <= (req_count >= 900 && req_count < 1200) ? 0 : 14;

         if (!storm_done && req_count >= 700) begin
            // Drive one entry's count into saturation.
            storm_done = 1'b1;
            idx = pick_held();
            repeat (258) send_req(entry_req(REQ_PIN, idx, next_tick()), 0, none);
            repeat (3) send_req(entry_req(REQ_UNPIN, idx, next_tick()), 0, none);
         end

         roll = $urandom_range(99);
         if (roll < 12) begin
            // Take every entry, hit the no-free case, then release with shared or spread ticks.
            any_free = 1'b1;
            while (any_free) begin
               send_req(read_req(8'($urandom), $urandom), 0, none);
               any_free = 1'b0;
               foreach (line_refs[i]) if (line_refs[i] == 0) any_free = 1'b1;
            end
            send_req(read_req(8'($urandom), $urandom), 0, none);
            send_req(read_req(pool_dev[$urandom_range(TAG_POOL - 1)],
                              pool_blk[$urandom_range(TAG_POOL - 1)]), 0, none);
            same_tick = $urandom_range(1);
            drain_tick = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
            start = $urandom_range(ENTRIES - 1);
            for (int i = 0; i < ENTRIES; i++) begin
               idx = 5'((start + i) % ENTRIES);
               while (line_refs[idx] != 0 && line_refs[idx] < 6) begin
                  send_req(entry_req(REQ_RELEASE, idx, same_tick ? drain_tick : next_tick()),
                           0, none);
               end
            end
         end else begin
            burst = $urandom_range(30, 8);
            repeat (burst) begin
               roll = $urandom_range(99);
               if (roll < 32) begin
                  start = $urandom_range(TAG_POOL - 1);
                  send_req(read_req(pool_dev[start], pool_blk[start]), 0, none);
               end else if (roll < 40) begin
                  send_req(read_req(8'($urandom), $urandom), 0, none);
               end else if (roll < 75) begin
                  send_req(entry_req(REQ_RELEASE, pick_held(), next_tick()), 0, none);
               end else if (roll < 82) begin
                  send_req(entry_req(REQ_PIN, pick_held(), next_tick()), 0, none);
               end else if (roll < 92) begin
                  send_req(entry_req(REQ_UNPIN, pick_held(), next_tick()), 0, none);
               end else begin
                  send_req('{kind: req_kind_type'($urandom_range(3)), device: 8'($urandom),
                             block: $urandom, index: 5'($urandom), tick: $urandom}, 0, none);
               end
            end
         end
      end
      req_valid <= 1'b0;

      while (grant_q.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);

      $display("%0d requests sent and %0d results checked, %0d mismatches", req_count,
               rsp_count, mismatch_count);
      $display("%0d hits, %0d no-free reads, %0d underflows, %0d pins at the count limit",
               hits_seen, nofree_seen, underflow_seen, saturate_seen);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
